// ===== hdl/pagsu_pkg.sv =====
// pagsu_pkg: shared types, constants and command codes for the
// profile alignment score unit; no dependencies
package pagsu_pkg;

    localparam int MAX_COLUMNS_DEF = 64;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int FRAC_BITS_DEF   = 12;

    localparam int SCORE_W = 24;
    localparam int CFG_W   = 16;
    localparam int CNT_W   = 16;

    localparam logic [1:0] CMD_LOAD_Q  = 2'd0;
    localparam logic [1:0] CMD_LOAD_S  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;
    localparam logic [1:0] CMD_CLEAR   = 2'd3;

    localparam logic [0:0] REG_GAP_OPEN   = 1'b0;
    localparam logic [0:0] REG_GAP_EXTEND = 1'b1;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [CNT_W-1:0] count_a;
        logic [CNT_W-1:0] count_c;
        logic [CNT_W-1:0] count_g;
        logic [CNT_W-1:0] count_t;
    } t_in_item;

    typedef struct packed {
        logic signed [SCORE_W-1:0] top_score;
        logic                      reverse_won;
        logic                      overflow_flag;
    } t_out_item;

    // one dp cell: match, insert, deletion, after-gap
    typedef struct packed {
        logic signed [SCORE_W-1:0] f;
        logic signed [SCORE_W-1:0] ins;
        logic signed [SCORE_W-1:0] del;
        logic signed [SCORE_W-1:0] fin;
    } t_cell;

    function automatic logic signed [SCORE_W-1:0] sat24(input logic signed [SCORE_W+1:0] v);
        logic signed [SCORE_W+1:0] hi;
        logic signed [SCORE_W+1:0] lo;
        hi = (SCORE_W+2)'((2**(SCORE_W-1)) - 1);
        lo = -(SCORE_W+2)'(2**(SCORE_W-1));
        if (v > hi) sat24 = hi[SCORE_W-1:0];
        else if (v < lo) sat24 = lo[SCORE_W-1:0];
        else sat24 = v[SCORE_W-1:0];
    endfunction

endpackage

// ===== hdl/pagsu_ram.sv =====
// pagsu_ram: generic single-port-write, single-read synchronous ram
// with a registered read; no dependencies
module pagsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/pagsu_norm.sv =====
// pagsu_norm: normalizes four column counts into probabilities with a
// shared restoring divider, one quotient bit per cycle; uses pagsu_pkg
module pagsu_norm #(
    parameter int COUNT_BITS = 16,
    parameter int FRAC_BITS  = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [4*pagsu_pkg::CNT_W-1:0] i_counts,
    output logic                   o_done,
    output logic [4*(FRAC_BITS+1)-1:0] o_col
);
    import pagsu_pkg::*;

    localparam int PW   = FRAC_BITS + 1;
    localparam int TW   = COUNT_BITS + 2;
    localparam int NW   = COUNT_BITS + FRAC_BITS + 2;
    localparam int QW   = NW;
    localparam int BCW  = $clog2(QW + 1);

    logic               r_busy, n_busy;
    logic [1:0]         r_lane, n_lane;
    logic [BCW-1:0]     r_bit, n_bit;
    logic [NW-1:0]      r_num, n_num;
    logic [TW:0]        r_rem, n_rem;
    logic [QW-1:0]      r_quo, n_quo;
    logic [TW-1:0]      r_tot;
    logic [4*COUNT_BITS-1:0] r_cnt;
    logic [4*PW-1:0]    r_col, n_col;
    logic               r_done, n_done;
    logic [COUNT_BITS-1:0] w_c [4];
    logic [TW-1:0]      w_tot;
    logic [TW:0]        w_den;
    logic [TW+1:0]      w_trial;

    always_comb begin
        for (int k = 0; k < 4; k++)
            w_c[k] = COUNT_BITS'(i_counts[(3-k)*CNT_W +: CNT_W]);
        w_tot = TW'(w_c[0]) + TW'(w_c[1]) + TW'(w_c[2]) + TW'(w_c[3]);
    end

    assign w_den      = {r_tot, 1'b0};
    // remainder stays below 2*total, so the trial keeps its top bit
    assign w_trial    = {r_rem, r_num[NW-1]};

    always_comb begin
        n_busy = r_busy;
        n_lane = r_lane;
        n_bit  = r_bit;
        n_num  = r_num;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_col  = r_col;
        n_done = 1'b0;
        if (r_busy) begin
            n_num = r_num << 1;
            if (w_trial >= {1'b0, w_den}) begin
                n_rem = (TW+1)'(w_trial - {1'b0, w_den});
                n_quo = {r_quo[QW-2:0], 1'b1};
            end else begin
                n_rem = w_trial[TW:0];
                n_quo = {r_quo[QW-2:0], 1'b0};
            end
            if (r_bit == BCW'(QW - 1)) begin
                n_col[(3-r_lane)*PW +: PW] = (r_tot == '0) ? '0 : n_quo[PW-1:0];
                n_bit = '0;
                n_rem = '0;
                if (r_lane == 2'd3) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end else begin
                    // numerator = (c << (F+1)) + total
                    n_lane = r_lane + 2'd1;
                    n_num  = (NW'(r_cnt[(2-r_lane)*COUNT_BITS +: COUNT_BITS])
                              << (FRAC_BITS + 1)) + NW'(r_tot);
                end
            end else begin
                n_bit = r_bit + BCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start ? 1'b1 : n_busy;
            r_done <= n_done;
        end
        if (i_start) begin
            r_lane <= '0;
            r_bit  <= '0;
            r_rem  <= '0;
            r_quo  <= '0;
            r_tot  <= w_tot;
            r_cnt  <= {w_c[0], w_c[1], w_c[2], w_c[3]};
            r_num  <= (NW'(w_c[0]) << (FRAC_BITS + 1)) + NW'(w_tot);
        end else begin
            r_lane <= n_lane;
            r_bit  <= n_bit;
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_num  <= n_num;
        end
        r_col <= n_col;
    end

    assign o_done = r_done;
    assign o_col  = r_col;
endmodule

// ===== hdl/pagsu_dp.sv =====
// pagsu_dp: row-by-row affine-gap dynamic programme over profiles held
// in rams, one cell per step; uses pagsu_pkg and pagsu_ram
module pagsu_dp #(
    parameter int MAX_COLUMNS = 64,
    parameter int FRAC_BITS   = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_reverse,
    input  logic [$clog2(MAX_COLUMNS+1)-1:0] i_qlen,
    input  logic [$clog2(MAX_COLUMNS+1)-1:0] i_slen,
    input  logic [pagsu_pkg::CFG_W-1:0]    i_open,
    input  logic [pagsu_pkg::CFG_W-1:0]    i_extend,
    output logic [$clog2(MAX_COLUMNS)-1:0] o_qaddr,
    input  logic [4*(FRAC_BITS+1)-1:0]     i_qcol,
    output logic [$clog2(MAX_COLUMNS)-1:0] o_saddr,
    input  logic [4*(FRAC_BITS+1)-1:0]     i_scol,
    output logic                          o_done,
    output logic signed [pagsu_pkg::SCORE_W-1:0] o_best
);
    import pagsu_pkg::*;

    localparam int AW  = $clog2(MAX_COLUMNS);
    localparam int LW  = $clog2(MAX_COLUMNS + 1);
    localparam int RAW = $clog2(MAX_COLUMNS + 1);
    localparam int PW  = FRAC_BITS + 1;
    localparam int SW  = 2 * PW + 3;
    localparam int CW  = $bits(t_cell);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_SQR  = 3'd2;
    localparam logic [2:0] ST_CELL = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]  r_st;
    logic [LW-1:0] r_i, r_j;
    logic signed [SCORE_W-1:0] r_best;
    t_cell       r_left, r_diag;
    logic [SW-1:0] r_sum;
    logic [CFG_W-1:0] r_op, r_ex;
    logic        r_rev;
    logic        r_done;
    logic        r_row0;

    logic        w_we;
    logic [RAW-1:0] w_waddr, w_raddr;
    t_cell       w_wcell, w_up;
    logic [CW-1:0] w_rdata;
    t_cell       w_new;
    logic signed [SCORE_W+1:0] w_m;
    logic [SW-1:0] w_sq;
    logic [PW-1:0] w_qp [4];
    logic [PW-1:0] w_sp [4];
    logic signed [SW-1:0] w_d [4];

    // previous row; row i-1 entry j read while computing (i,j)
    pagsu_ram #(.WIDTH(CW), .DEPTH(MAX_COLUMNS + 1)) u_row (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wcell),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    assign w_up    = r_row0 ? '0 : t_cell'(w_rdata);
    assign w_raddr = RAW'(r_j);
    assign o_qaddr = AW'(r_i - LW'(1));
    assign o_saddr = r_rev ? AW'(i_slen - r_j) : AW'(r_j - LW'(1));

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_qp[k] = i_qcol[(3-k)*PW +: PW];
            w_sp[k] = r_rev ? i_scol[k*PW +: PW] : i_scol[(3-k)*PW +: PW];
            w_d[k]  = $signed(SW'(w_qp[k])) - $signed(SW'(w_sp[k]));
        end
        w_sq = '0;
        for (int k = 0; k < 4; k++)
            w_sq = w_sq + $unsigned(w_d[k] * w_d[k]);
    end

    always_comb begin
        logic signed [SCORE_W+1:0] rnd;
        logic signed [SCORE_W+1:0] a, b, v;
        rnd = (SCORE_W+2)'((r_sum + SW'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
        w_m = (SCORE_W+2)'(2 << FRAC_BITS) - rnd;
        w_new.f = sat24(w_m + (SCORE_W+2)'(r_diag.f));
        a = (SCORE_W+2)'(w_up.f) - (SCORE_W+2)'($signed({1'b0, r_op}));
        b = (SCORE_W+2)'(w_up.ins) - (SCORE_W+2)'($signed({1'b0, r_ex}));
        w_new.ins = sat24(a >= b ? a : b);
        a = (SCORE_W+2)'(r_left.f) - (SCORE_W+2)'($signed({1'b0, r_op}));
        b = (SCORE_W+2)'(r_left.del) - (SCORE_W+2)'($signed({1'b0, r_ex}));
        w_new.del = sat24(a >= b ? a : b);
        v = (r_diag.ins >= r_diag.del) ? (SCORE_W+2)'(r_diag.ins) : (SCORE_W+2)'(r_diag.del);
        v = (v >= (SCORE_W+2)'(r_diag.fin)) ? v : (SCORE_W+2)'(r_diag.fin);
        w_new.fin = sat24(v + w_m);
    end

    assign w_we    = (r_st == ST_CELL);
    assign w_waddr = RAW'(r_j);
    assign w_wcell = w_new;

    always_ff @(posedge i_clk) begin
        logic signed [SCORE_W-1:0] mb;
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_st)
                ST_IDLE: begin
                    if (i_start) begin
                        r_rev  <= i_reverse;
                        r_op   <= i_open;
                        r_ex   <= i_extend;
                        r_best <= '0;
                        r_i    <= LW'(1);
                        r_j    <= LW'(1);
                        r_row0 <= 1'b1;
                        r_left <= '0;
                        r_diag <= '0;
                        if (i_qlen == '0 || i_slen == '0) r_st <= ST_DONE;
                        else r_st <= ST_READ;
                    end
                end
                ST_READ: r_st <= ST_SQR;
                ST_SQR: begin
                    r_sum <= w_sq;
                    r_st  <= ST_CELL;
                end
                ST_CELL: begin
                    mb = r_best;
                    if (w_new.f > mb) mb = w_new.f;
                    if (w_new.ins > mb) mb = w_new.ins;
                    if (w_new.del > mb) mb = w_new.del;
                    if (w_new.fin > mb) mb = w_new.fin;
                    r_best <= mb;
                    r_left <= w_new;
                    r_diag <= w_up;
                    r_st   <= ST_READ;
                    if (r_j == i_slen) begin
                        r_j    <= LW'(1);
                        r_left <= '0;
                        r_diag <= '0;
                        r_row0 <= 1'b0;
                        if (r_i == i_qlen) r_st <= ST_DONE;
                        else r_i <= r_i + LW'(1);
                    end else begin
                        r_j <= r_j + LW'(1);
                    end
                end
                ST_DONE: begin
                    r_done <= 1'b1;
                    r_st   <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_best = r_best;
endmodule

// ===== hdl/profile_alignment_affine_gap_score_unit.sv =====
// profile_alignment_affine_gap_score_unit: top level; profile rams,
// command control and result register; uses pagsu_pkg, pagsu_ram,
// pagsu_norm and pagsu_dp
//
// A load normalizes one column in the shared normalizer (one quotient bit
// per cycle) and stores it in a profile ram, or sets the overflow flag if
// that profile is full; clear empties both profiles. A compute runs two
// passes, forward then reverse, each stepping one cell at a time through
// the row ram and profile rams. Results wait in an output register; the
// next command is taken once a result has been handed over.
module profile_alignment_affine_gap_score_unit #(
    parameter int MAX_COLUMNS = pagsu_pkg::MAX_COLUMNS_DEF,
    parameter int COUNT_BITS  = pagsu_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS   = pagsu_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  pagsu_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output pagsu_pkg::t_out_item o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [0:0]           i_cfg_index,
    input  logic [pagsu_pkg::CFG_W-1:0] i_cfg_data
);
    import pagsu_pkg::*;

    localparam int AW = $clog2(MAX_COLUMNS);
    localparam int LW = $clog2(MAX_COLUMNS + 1);
    localparam int PW = FRAC_BITS + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_NORM = 3'd1;
    localparam logic [2:0] ST_FWD  = 3'd2;
    localparam logic [2:0] ST_REV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  r_st;
    logic [LW-1:0] r_qlen, r_slen;
    logic        r_ovf;
    logic        r_is_s;
    logic [CFG_W-1:0] r_open, r_ext;
    logic signed [SCORE_W-1:0] r_fwd;
    t_out_item   r_out;
    logic        r_start_dp, r_rev_dp;

    logic        w_acc;
    logic        w_norm_start, w_norm_done;
    logic [4*PW-1:0] w_col, w_qcol, w_scol;
    logic [AW-1:0] w_qaddr, w_saddr;
    logic        w_dp_done;
    logic signed [SCORE_W-1:0] w_dp_best;

    assign o_in_ready  = (r_st == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_acc       = i_in_valid && o_in_ready;
    assign w_norm_start = w_acc && (i_in_data.cmd == CMD_LOAD_Q && r_qlen < LW'(MAX_COLUMNS)
                        || i_in_data.cmd == CMD_LOAD_S && r_slen < LW'(MAX_COLUMNS));

    pagsu_norm #(.COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_norm (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_norm_start),
        .i_counts({i_in_data.count_a, i_in_data.count_c, i_in_data.count_g,
                   i_in_data.count_t}),
        .o_done(w_norm_done), .o_col(w_col)
    );

    pagsu_ram #(.WIDTH(4*PW), .DEPTH(MAX_COLUMNS)) u_qram (
        .i_clk(i_clk), .i_we(w_norm_done && !r_is_s), .i_waddr(AW'(r_qlen)),
        .i_wdata(w_col), .i_raddr(w_qaddr), .o_rdata(w_qcol)
    );

    pagsu_ram #(.WIDTH(4*PW), .DEPTH(MAX_COLUMNS)) u_sram (
        .i_clk(i_clk), .i_we(w_norm_done && r_is_s), .i_waddr(AW'(r_slen)),
        .i_wdata(w_col), .i_raddr(w_saddr), .o_rdata(w_scol)
    );

    pagsu_dp #(.MAX_COLUMNS(MAX_COLUMNS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start_dp), .i_reverse(r_rev_dp),
        .i_qlen(r_qlen), .i_slen(r_slen), .i_open(r_open), .i_extend(r_ext),
        .o_qaddr(w_qaddr), .i_qcol(w_qcol), .o_saddr(w_saddr), .i_scol(w_scol),
        .o_done(w_dp_done), .o_best(w_dp_best)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= ST_IDLE;
            r_qlen     <= '0;
            r_slen     <= '0;
            r_ovf      <= 1'b0;
            r_open     <= CFG_W'(4096);
            r_ext      <= CFG_W'(2048);
            r_start_dp <= 1'b0;
            r_rev_dp   <= 1'b0;
        end else begin
            r_start_dp <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_GAP_OPEN:   r_open <= i_cfg_data;
                    REG_GAP_EXTEND: r_ext  <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_st)
                ST_IDLE: begin
                    if (w_acc) begin
                        unique case (i_in_data.cmd) inside
                            CMD_LOAD_Q, CMD_LOAD_S: begin
                                r_is_s <= (i_in_data.cmd == CMD_LOAD_S);
                                if (w_norm_start) r_st <= ST_NORM;
                                else r_ovf <= 1'b1;
                            end
                            CMD_CLEAR: begin
                                r_qlen <= '0;
                                r_slen <= '0;
                                r_ovf  <= 1'b0;
                            end
                            default: begin
                                r_start_dp <= 1'b1;
                                r_rev_dp   <= 1'b0;
                                r_st       <= ST_FWD;
                            end
                        endcase
                    end
                end
                ST_NORM: begin
                    if (w_norm_done) begin
                        if (r_is_s) r_slen <= r_slen + LW'(1);
                        else r_qlen <= r_qlen + LW'(1);
                        r_st <= ST_IDLE;
                    end
                end
                ST_FWD: begin
                    if (w_dp_done) begin
                        r_fwd      <= w_dp_best;
                        r_start_dp <= 1'b1;
                        r_rev_dp   <= 1'b1;
                        r_st       <= ST_REV;
                    end
                end
                ST_REV: begin
                    if (w_dp_done) begin
                        r_out.top_score     <= (r_fwd > w_dp_best) ? r_fwd : w_dp_best;
                        r_out.reverse_won   <= !(r_fwd > w_dp_best);
                        r_out.overflow_flag <= r_ovf;
                        r_st <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (i_out_ready) r_st <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = (r_st == ST_OUT);
    assign o_out_data  = r_out;
endmodule
